/* rtl/core/lpdf_pkg.sv */
// ----------------------------------------------------------------------------
// lpdf_pkg: shared definitions of the length-prefixed deframer
// Register indexes, reset values, widths, controller states and the command
// and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lpdf_pkg;

   // Largest header that the header store holds.
   localparam int MaxHeader = 16;
   localparam int IdxW      = $clog2(MaxHeader);
   localparam int CntW      = $clog2(MaxHeader + 1);

   // Fixed field widths.
   localparam int ByteW   = 8;
   localparam int PosW    = 32;
   localparam int MagicW  = 16;
   localparam int HdrW    = 5;
   localparam int CsrIdxW = 2;
   localparam int CsrW    = 32;

   // Header layout.
   localparam logic [PosW-1:0] LenBytes = 32'd4;
   localparam logic [PosW-1:0] KeyEnd   = 32'd6;
   localparam logic [PosW-1:0] HdrLimit = 32'(MaxHeader);

   // Register indexes.
   localparam logic [CsrIdxW-1:0] CsrHeaderBytes = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrMaxMessage  = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrMagic       = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrOffset      = 2'd3;

   // Register reset values.
   localparam logic [HdrW-1:0]   RstHeaderBytes = 5'd6;
   localparam logic [CsrW-1:0]   RstMaxMessage  = 32'd65536;
   localparam logic [MagicW-1:0] RstMagic       = 16'd0;
   localparam logic [HdrW-1:0]   RstOffset      = 5'd4;

   // Error kinds.
   localparam logic ErrLength = 1'b0;
   localparam logic ErrMagic  = 1'b1;

   typedef enum logic [1:0] {
      ST_HEAD,
      ST_FLUSH,
      ST_BODY,
      ST_DEAD
   } state_type;

   // Commands from the controller.
   typedef struct packed {
      logic head_take;
      logic flush_take;
      logic body_take;
   } cmd_type;

   // Status from the datapath.
   typedef struct packed {
      logic at_check;
      logic len_bad;
      logic magic_bad;
      logic flush_more;
      logic is_last;
   } status_type;

endpackage

/* rtl/core/lpdf_ctrl.sv */
// ----------------------------------------------------------------------------
// lpdf_ctrl: deframer controller
// Sequences header collection, header flush, body streaming and the dead
// state after an error, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lpdf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  lpdf_pkg::status_type status,
   output lpdf_pkg::cmd_type    cmd
);
   import lpdf_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      load;

   // State and valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HEAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The output register can take a new item when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      load      = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         ST_HEAD: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               cmd.head_take = 1'b1;
               if (status.at_check) begin
                  if (status.len_bad || status.magic_bad) begin
                     load     = 1'b1;
                     state_in = ST_DEAD;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               cmd.flush_take = 1'b1;
               load           = 1'b1;
               if (!status.flush_more) begin
                  state_in = status.is_last ? ST_HEAD : ST_BODY;
               end
            end
         end
         ST_BODY: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               cmd.body_take = 1'b1;
               load          = 1'b1;
               if (status.is_last) begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_DEAD: begin
            // Every byte is taken and dropped.
            req_stall = 1'b0;
         end
         default: begin
            state_in = ST_HEAD;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/lpdf_datapath.sv */
// ----------------------------------------------------------------------------
// lpdf_datapath: deframer datapath
// Holds the configuration registers, the length and key accumulators, the
// header store, the flush pointer and the result register.
// ----------------------------------------------------------------------------
module lpdf_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_en,
   input  logic [lpdf_pkg::CsrIdxW-1:0] csr_index,
   input  logic [lpdf_pkg::CsrW-1:0]  csr_data,
   input  logic [lpdf_pkg::ByteW-1:0] req_stream_byte,
   input  lpdf_pkg::cmd_type          cmd,
   output lpdf_pkg::status_type       status,
   output logic [lpdf_pkg::ByteW-1:0] rsp_payload_byte,
   output logic                      rsp_message_start,
   output logic                      rsp_message_end,
   output logic                      rsp_is_error,
   output logic                      rsp_error_kind,
   output logic                      rsp_run_end
);
   import lpdf_pkg::*;

   // Configuration registers.
   logic [HdrW-1:0]   hdr_ff;
   logic [CsrW-1:0]   max_ff;
   logic [MagicW-1:0] magic_cfg_ff;
   logic [HdrW-1:0]   offset_ff;

   // Message state.
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [PosW-1:0]   len_ff, len_in;
   logic [MagicW-1:0] magic_ff, magic_in;
   logic [CntW-1:0]   idx_ff, idx_in;
   logic              first_ff, first_in;
   logic [ByteW-1:0]  held_ff, held_in;
   logic [ByteW-1:0]  store [MaxHeader];

   // Result register.
   logic [ByteW-1:0]  data_ff, data_in;
   logic              start_ff, start_in;
   logic              end_ff, end_in;
   logic              err_ff, err_in;
   logic              kind_ff, kind_in;
   logic              run_ff, run_in;
   logic              out_load;

   logic [PosW-1:0]   hdr_wide;
   logic [PosW-1:0]   hdr_eff;
   logic [PosW-1:0]   offset_wide;
   logic [PosW-1:0]   skip;
   logic [MagicW-1:0] magic_upd;
   logic [MagicW-1:0] key;
   logic              in_key;
   logic              store_write;
   logic              store_read;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff       <= RstHeaderBytes;
         max_ff       <= RstMaxMessage;
         magic_cfg_ff <= RstMagic;
         offset_ff    <= RstOffset;
      end else if (csr_write_en) begin
         case (csr_index)
            CsrHeaderBytes: hdr_ff       <= csr_data[HdrW-1:0];
            CsrMaxMessage:  max_ff       <= csr_data;
            CsrMagic:       magic_cfg_ff <= csr_data[MagicW-1:0];
            CsrOffset:      offset_ff    <= csr_data[HdrW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Header length clamped to LenBytes..HdrLimit, and the clipped skip count.
   always_comb begin
      hdr_wide    = PosW'(hdr_ff);
      offset_wide = PosW'(offset_ff);
      if (hdr_wide < LenBytes) begin
         hdr_eff = LenBytes;
      end else if (hdr_wide > HdrLimit) begin
         hdr_eff = HdrLimit;
      end else begin
         hdr_eff = hdr_wide;
      end
      skip = (offset_wide > pos_ff) ? pos_ff : offset_wide;
   end

   // Key as seen with the current byte; missing key bytes count as zero.
   always_comb begin
      in_key    = (pos_ff >= LenBytes) && (pos_ff < KeyEnd);
      magic_upd = in_key ? {magic_ff[ByteW-1:0], req_stream_byte} : magic_ff;
      key       = (pos_ff == LenBytes) ? {magic_upd[ByteW-1:0], {ByteW{1'b0}}} : magic_upd;
   end

   // Status toward the controller.
   always_comb begin
      status.at_check   = (pos_ff >= hdr_eff);
      status.len_bad    = (len_ff <= pos_ff) || (len_ff > max_ff);
      status.magic_bad  = (magic_cfg_ff != '0) && (key != magic_cfg_ff);
      status.flush_more = (PosW'(idx_ff) < pos_ff);
      status.is_last    = ({1'b0, pos_ff} + 33'd1) == {1'b0, len_ff};
   end

   // Next values of message state and result register.
   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      magic_in    = magic_ff;
      idx_in      = idx_ff;
      first_in    = first_ff;
      held_in     = held_ff;
      data_in     = data_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      err_in      = err_ff;
      kind_in     = kind_ff;
      run_in      = run_ff;
      out_load    = 1'b0;
      store_write = 1'b0;
      store_read  = 1'b0;

      if (cmd.head_take) begin
         if (pos_ff < LenBytes) begin
            len_in = {len_ff[PosW-ByteW-1:0], req_stream_byte};
         end
         magic_in = magic_upd;
         if (!status.at_check) begin
            store_write = 1'b1;
            pos_in      = pos_ff + 32'd1;
         end else if (status.len_bad || status.magic_bad) begin
            out_load = 1'b1;
            data_in  = '0;
            start_in = 1'b0;
            end_in   = 1'b0;
            err_in   = 1'b1;
            kind_in  = status.len_bad ? ErrLength : ErrMagic;
            run_in   = 1'b1;
         end else begin
            held_in  = req_stream_byte;
            idx_in   = skip[CntW-1:0];
            first_in = 1'b1;
         end
      end

      // Flush of the stored header, then the checking byte.
      if (cmd.flush_take) begin
         out_load = 1'b1;
         err_in   = 1'b0;
         kind_in  = 1'b0;
         start_in = first_ff;
         first_in = 1'b0;
         if (status.flush_more) begin
            store_read = 1'b1;
            end_in     = 1'b0;
            run_in     = 1'b0;
            idx_in     = idx_ff + CntW'(1);
         end else begin
            data_in = held_ff;
            end_in  = status.is_last;
            run_in  = 1'b1;
            if (status.is_last) begin
               pos_in   = '0;
               len_in   = '0;
               magic_in = '0;
            end else begin
               pos_in = pos_ff + 32'd1;
            end
         end
      end

      // Body bytes pass straight through.
      if (cmd.body_take) begin
         out_load = 1'b1;
         data_in  = req_stream_byte;
         start_in = 1'b0;
         end_in   = status.is_last;
         err_in   = 1'b0;
         kind_in  = 1'b0;
         run_in   = 1'b1;
         if (status.is_last) begin
            pos_in   = '0;
            len_in   = '0;
            magic_in = '0;
         end else begin
            pos_in = pos_ff + 32'd1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         len_ff   <= '0;
         magic_ff <= '0;
         idx_ff   <= '0;
         first_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         magic_ff <= magic_in;
         idx_ff   <= idx_in;
         first_ff <= first_in;
      end
   end

   // Payload registers; a stored header byte is read straight into the result.
   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (out_load) begin
         data_ff  <= store_read ? store[idx_ff[IdxW-1:0]] : data_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         err_ff   <= err_in;
         kind_ff  <= kind_in;
         run_ff   <= run_in;
      end
   end

   // Header store.
   always_ff @(posedge clock) begin
      if (store_write) begin
         store[pos_ff[IdxW-1:0]] <= req_stream_byte;
      end
   end

   assign rsp_payload_byte  = data_ff;
   assign rsp_message_start = start_ff;
   assign rsp_message_end   = end_ff;
   assign rsp_is_error      = err_ff;
   assign rsp_error_kind    = kind_ff;
   assign rsp_run_end       = run_ff;

endmodule

/* rtl/core/length_prefixed_deframer_unit.sv */
// ----------------------------------------------------------------------------
// length_prefixed_deframer_unit: length-prefixed message deframer
// Cuts a byte stream into messages with a big-endian length and a 16-bit key
// in the header, checks both, and delivers payload bytes with start and end
// flags, or one error item after which the stream is dropped.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake          Payload
// req_      in         valid / stall      stream_byte
// rsp_      out        valid / stall      payload_byte, flags, error_kind
// csr_      in         write_en           index, data
//
// Header and body bytes are taken while the result register is free.
// The checking byte is first checked; the stored header bytes from the clipped
// offset are then flushed, and the checking byte itself goes out last.
// The flush reads the header store one entry a cycle while the output is free.
// Reset is synchronous; it restores register defaults and a fresh message.
// A stalled result holds in the output register; input is stalled only while
// that register is full and stalled, or during the flush.
module length_prefixed_deframer_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [lpdf_pkg::CsrIdxW-1:0] csr_index,
   input  logic [lpdf_pkg::CsrW-1:0]   csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lpdf_pkg::ByteW-1:0]  req_stream_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lpdf_pkg::ByteW-1:0]  rsp_payload_byte,
   output logic                       rsp_message_start,
   output logic                       rsp_message_end,
   output logic                       rsp_is_error,
   output logic                       rsp_error_kind,
   output logic                       rsp_run_end
);
   import lpdf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller.
   lpdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   lpdf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_stream_byte   (req_stream_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_message_start (rsp_message_start),
      .rsp_message_end   (rsp_message_end),
      .rsp_is_error      (rsp_is_error),
      .rsp_error_kind    (rsp_error_kind),
      .rsp_run_end       (rsp_run_end)
   );

endmodule

/* bench/length_prefixed_deframer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_deframer_checker: deframer result predictor and comparator
// Watches the register, stream and result ports of the deframer. Every byte
// accepted on the stream side is run through a local model of the deframer,
// and the items it must produce are queued. Every item accepted on the result
// side is compared field by field with the oldest queued item.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [lpdf_pkg::CsrIdxW-1:0] csr_index,
   input  logic [lpdf_pkg::CsrW-1:0]    csr_data,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [lpdf_pkg::ByteW-1:0]   req_stream_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [lpdf_pkg::ByteW-1:0]   rsp_payload_byte,
   input  logic                         rsp_message_start,
   input  logic                         rsp_message_end,
   input  logic                         rsp_is_error,
   input  logic                         rsp_error_kind,
   input  logic                         rsp_run_end,
   output int                           failures,
   output int                           pending,
   output int                           results_checked,
   output int                           messages_delivered
);
   import lpdf_pkg::*;

   localparam int OwedDepth = 64;
   localparam int OwedW     = $clog2(OwedDepth);

   typedef enum logic [1:0] {
      IN_HEADER,
      IN_BODY,
      CLOSED
   } deframe_phase_type;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic             first;
      logic             last;
      logic             err;
      logic             kind;
      logic             run_last;
   } deframe_item_type;

   // Register copies as the block should see them.
   logic [HdrW-1:0]   cfg_header;
   logic [CsrW-1:0]   cfg_max;
   logic [MagicW-1:0] cfg_magic;
   logic [HdrW-1:0]   cfg_offset;

   // Framing state of the local model.
   deframe_phase_type phase;
   logic [PosW-1:0]   position;
   logic [PosW-1:0]   length;
   logic [MagicW-1:0] key_accum;
   logic [ByteW-1:0]  header_copy [MaxHeader];

   // Items the block still owes, oldest first, in a ring buffer.
   deframe_item_type  owed_items [OwedDepth];
   logic [OwedW-1:0]  owed_rd;
   logic [OwedW-1:0]  owed_wr;
   int                owed_count;

   task automatic start_message();
      phase = IN_HEADER;
      position = '0;
      length = '0;
      key_accum = '0;
   endtask

   // Appends one expected item behind the ones already owed.
   task automatic owe_item(input logic [ByteW-1:0] data, input logic first,
                           input logic last, input logic err, input logic kind,
                           input logic run_last);
      deframe_item_type item;
      item.data = data;
      item.first = first;
      item.last = last;
      item.err = err;
      item.kind = kind;
      item.run_last = run_last;
      if (owed_count == OwedDepth) begin
         $error("expected item buffer overflow");
         failures++;
      end else begin
         owed_items[owed_wr] = item;
         owed_wr = owed_wr + OwedW'(1);
         owed_count++;
      end
   endtask

   // Works out the items that one stream byte causes and queues them.
   task automatic deframe_byte(input logic [ByteW-1:0] b);
      logic [PosW-1:0]   hdr_len;
      logic [PosW-1:0]   pos;
      logic [PosW-1:0]   skip;
      logic [PosW-1:0]   i;
      logic [MagicW-1:0] key;
      logic              last;
      int                n;
      n = 0;
      if (phase == CLOSED) return;

      // Body bytes pass straight through, one item each.
      if (phase == IN_BODY) begin
         last = ({1'b0, position} + 33'd1 == {1'b0, length});
         owe_item(b, 1'b0, last, 1'b0, 1'b0, 1'b1);
         if (last) start_message();
         else position = position + 1;
         return;
      end

      // The header length register is clamped between the length field and what the store can hold.
      if (PosW'(cfg_header) < LenBytes) hdr_len = LenBytes;
      else if (PosW'(cfg_header) > HdrLimit) hdr_len = HdrLimit;
      else hdr_len = PosW'(cfg_header);
      pos = position;

      if (pos < LenBytes) length = {length[PosW-ByteW-1:0], b};
      else if (pos < KeyEnd) key_accum = {key_accum[ByteW-1:0], b};

      if (pos < hdr_len) begin
         header_copy[pos[IdxW-1:0]] = b;
         position = pos + 1;
         return;
      end

      // First byte past the header: length, then key.
      key = (pos == LenBytes) ? {key_accum[ByteW-1:0], 8'h00} : key_accum;
      if (length <= pos || length > cfg_max) begin
         owe_item(8'h00, 1'b0, 1'b0, 1'b1, ErrLength, 1'b1);
         phase = CLOSED;
         return;
      end
      if (cfg_magic != '0 && key != cfg_magic) begin
         owe_item(8'h00, 1'b0, 1'b0, 1'b1, ErrMagic, 1'b1);
         phase = CLOSED;
         return;
      end

      // Flush the stored header from the clipped offset, then this byte.
      skip = ({27'd0, cfg_offset} > pos) ? pos : {27'd0, cfg_offset};
      for (i = skip; i < pos && i < HdrLimit; i++) begin
         owe_item(header_copy[i[IdxW-1:0]], n == 0, 1'b0, 1'b0, 1'b0, 1'b0);
         n++;
      end
      last = ({1'b0, pos} + 33'd1 == {1'b0, length});
      owe_item(b, n == 0, last, 1'b0, 1'b0, 1'b1);
      if (last) begin
         start_message();
      end else begin
         phase = IN_BODY;
         position = pos + 1;
      end
   endtask

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         failures++;
      end
   endfunction

   function automatic void check_flag(string field, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : watch_ports
      deframe_item_type want;
      if (reset) begin
         cfg_header = RstHeaderBytes;
         cfg_max = RstMaxMessage;
         cfg_magic = RstMagic;
         cfg_offset = RstOffset;
         start_message();
         owed_rd = '0;
         owed_wr = '0;
         owed_count = 0;
         failures = 0;
         results_checked = 0;
         messages_delivered = 0;
      end else begin
         // Predict first, so the queue holds every owed item before a result is compared.
         if (req_valid && !req_stall) deframe_byte(req_stream_byte);

         if (rsp_valid && !rsp_stall) begin
            if (owed_count == 0) begin
               $error("result item with none expected: payload_byte %0h, is_error %0b",
                      rsp_payload_byte, rsp_is_error);
               failures++;
            end else begin
               want = owed_items[owed_rd];
               owed_rd = owed_rd + OwedW'(1);
               owed_count--;
               results_checked++;
               check_field("payload_byte", want.data, rsp_payload_byte);
               check_flag("message_start", want.first, rsp_message_start);
               check_flag("message_end", want.last, rsp_message_end);
               check_flag("is_error", want.err, rsp_is_error);
               check_flag("error_kind", want.kind, rsp_error_kind);
               check_flag("run_end", want.run_last, rsp_run_end);
               if (want.last && !want.err) messages_delivered++;
            end
         end

         // A write takes effect for bytes after this edge.
         if (csr_write_en) begin
            case (csr_index)
               CsrHeaderBytes: cfg_header = csr_data[HdrW-1:0];
               CsrMaxMessage:  cfg_max = csr_data;
               CsrMagic:       cfg_magic = csr_data[MagicW-1:0];
               CsrOffset:      cfg_offset = csr_data[HdrW-1:0];
               default: begin
               end
            endcase
         end
      end
      pending = owed_count;
   end

endmodule

/* bench/length_prefixed_deframer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_deframer_unit_tb: stimulus and verdict for the deframer
// Feeds framed byte streams under a range of register settings: short and
// clamped headers, clipped offsets, the key check, the smallest and largest
// maximum lengths and a header length lowered part way through a header.
// Both sides idle at random, with one long receiver hold-off. The stream is
// closed at the end by one error. The checker beside the block does the
// comparing; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_unit_tb;
   import lpdf_pkg::*;

   localparam int STREAM_BYTES    = 50;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int CYCLE_LIMIT     = 1000000;

   typedef enum {
      CLOSE_SHORT,
      CLOSE_LONG,
      CLOSE_KEY
   } close_reason_type;

   logic               clock;
   logic               reset;
   logic               csr_write_en;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0]    csr_data;
   logic               req_valid;
   logic               req_stall;
   logic [ByteW-1:0]   req_stream_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [ByteW-1:0]   rsp_payload_byte;
   logic               rsp_message_start;
   logic               rsp_message_end;
   logic               rsp_is_error;
   logic               rsp_error_kind;
   logic               rsp_run_end;

   int failures;
   int pending;
   int results_checked;
   int messages_delivered;
   int cycles = 0;
   int bytes_sent = 0;
   int reg_writes = 0;

   logic hold_off_request;
   logic gapless;

   // Register values last written, used to build legal messages.
   logic [HdrW-1:0]   hdr_reg;
   logic [CsrW-1:0]   max_reg;
   logic [MagicW-1:0] magic_reg;
   logic [HdrW-1:0]   offset_reg;

   length_prefixed_deframer_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_message_start (rsp_message_start),
      .rsp_message_end   (rsp_message_end),
      .rsp_is_error      (rsp_is_error),
      .rsp_error_kind    (rsp_error_kind),
      .rsp_run_end       (rsp_run_end)
   );

   length_prefixed_deframer_checker deframe_watch (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_message_start  (rsp_message_start),
      .rsp_message_end    (rsp_message_end),
      .rsp_is_error       (rsp_is_error),
      .rsp_error_kind     (rsp_error_kind),
      .rsp_run_end        (rsp_run_end),
      .failures           (failures),
      .pending            (pending),
      .results_checked    (results_checked),
      .messages_delivered (messages_delivered)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("length_prefixed_deframer_unit: mismatch");
         $finish;
      end
   end

   // Receiver stall: open stretches, short and long stalls, and one hold-off.
   initial begin : result_stall_gen
      logic hold_off_done;
      hold_off_done = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_stall <= 1'b1;
            hold_off_done = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  rsp_stall <= 1'b0;
                  repeat ($urandom_range(10, 40)) @(negedge clock);
               end
               2: begin
                  rsp_stall <= 1'b1;
                  repeat ($urandom_range(8, 30)) @(negedge clock);
               end
               3, 4, 5: begin
                  rsp_stall <= 1'b1;
                  repeat ($urandom_range(1, 3)) @(negedge clock);
               end
               default: begin
                  rsp_stall <= 1'b0;
                  @(negedge clock);
               end
            endcase
         end
      end
   end

   function automatic int header_len_in_use();
      if (hdr_reg < 5'd4) return 4;
      if (hdr_reg > 5'(MaxHeader)) return MaxHeader;
      return int'(hdr_reg);
   endfunction

   // Byte idx of a message: big-endian length, then the key, then any content.
   function automatic logic [7:0] message_byte(logic [31:0] len, logic [15:0] key, int idx);
      if (idx < 4) return len[8 * (3 - idx) +: 8];
      if (idx == 4) return key[15:8];
      if (idx == 5) return key[7:0];
      return 8'($urandom_range(0, 255));
   endfunction

   // Offers one item and returns at the falling edge after it is taken.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      int pick;
      pick = $urandom_range(0, 19);
      if (gapless || pick < 11) gap = 0;
      else if (pick < 18) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 25);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_span(input logic [31:0] len, input logic [15:0] key,
                            input int from, input int upto);
      for (int i = from; i < upto; i++) send_byte(message_byte(len, key, i));
   endtask

   task automatic send_message(input logic [31:0] len, input logic [15:0] key);
      send_span(len, key, 0, int'(len));
   endtask

   // Stops offering and waits until every owed item is out and the block is quiet.
   task automatic go_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrW-1:0] value);
      case (idx)
         CsrHeaderBytes: hdr_reg = value[HdrW-1:0];
         CsrMaxMessage:  max_reg = value;
         CsrMagic:       magic_reg = value[MagicW-1:0];
         CsrOffset:      offset_reg = value[HdrW-1:0];
         default: begin
         end
      endcase
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      reg_writes++;
   endtask

   // New random settings; unused upper data bits carry noise.
   task automatic random_settings();
      int h;
      logic [4:0] hdr;
      logic [15:0] magic;
      logic [31:0] max_len;
      hdr = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(4, 16));
      write_reg(CsrHeaderBytes, ($urandom() & 32'hFFFF_FFE0) | {27'd0, hdr});
      h = header_len_in_use();
      write_reg(CsrOffset, ($urandom() & 32'hFFFF_FFE0) | 32'($urandom_range(0, 31)));
      magic = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535)) : 16'h0000;
      // A 4-byte header only ever sees the key's high byte.
      if (h == 4) magic = magic & 16'hFF00;
      write_reg(CsrMagic, ($urandom() & 32'hFFFF_0000) | {16'd0, magic});
      case ($urandom_range(0, 3))
         0:       max_len = 32'hFFFF_FFFF;
         1:       max_len = 32'd65536;
         default: max_len = 32'(h + 1 + $urandom_range(0, 40));
      endcase
      write_reg(CsrMaxMessage, max_len);
   endtask

   // A length that passes the check; mostly short, now and then longer.
   function automatic logic [31:0] legal_length();
      longint span;
      int extra;
      span = longint'(max_reg) - header_len_in_use() - 1;
      if (span > 40) span = 40;
      if ($urandom_range(0, 7) == 0) extra = $urandom_range(0, int'(span));
      else extra = $urandom_range(0, (span < 12) ? int'(span) : 12);
      return 32'(header_len_in_use() + 1 + extra);
   endfunction

   function automatic logic [15:0] legal_key();
      return (magic_reg != 16'h0000) ? magic_reg : 16'($urandom_range(0, 65535));
   endfunction

   initial begin : stimulus
      int random_goal;
      int h;
      logic [31:0] len;
      logic [15:0] key;
      close_reason_type reason;

      reset = 1'b1;
      req_valid = 1'b0;
      req_stream_byte = '0;
      csr_write_en = 1'b0;
      csr_index = CsrHeaderBytes;
      csr_data = '0;
      hold_off_request = 1'b0;
      gapless = 1'b0;
      hdr_reg = RstHeaderBytes;
      max_reg = RstMaxMessage;
      magic_reg = RstMagic;
      offset_reg = RstOffset;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: the shortest message ends on its checking byte.
      send_message(32'd7, 16'hFFFF);
      send_message(32'd9, 16'h0000);
      go_idle();

      // A header register below four acts as four; the key is the high byte only.
      write_reg(CsrHeaderBytes, 32'd0);
      write_reg(CsrOffset, 32'd0);
      write_reg(CsrMagic, 32'h5A00);
      send_message(32'd5, 16'h5A00);
      send_message(32'd8, 16'h5A00);
      go_idle();

      // A header register above the store acts as sixteen; an offset past the
      // header leaves only the checking byte, which then starts the message.
      write_reg(CsrHeaderBytes, 32'd31);
      write_reg(CsrOffset, 32'd31);
      write_reg(CsrMagic, 32'h0);
      send_message(32'd17, 16'h1234);
      go_idle();

      // The whole header flushed ahead of the checking byte.
      write_reg(CsrOffset, 32'd0);
      send_message(32'd18, 16'hC3C3);
      go_idle();

      // Five-byte header, where the checking byte completes the key, with a
      // maximum length of seven.
      write_reg(CsrHeaderBytes, 32'd5);
      write_reg(CsrOffset, 32'd2);
      write_reg(CsrMagic, 32'hBEEF);
      write_reg(CsrMaxMessage, 32'd7);
      send_message(32'd7, 16'hBEEF);
      send_message(32'd6, 16'hBEEF);
      go_idle();

      // Header length lowered below the bytes already taken in.
      write_reg(CsrHeaderBytes, 32'd12);
      write_reg(CsrOffset, 32'd3);
      write_reg(CsrMagic, 32'h0);
      write_reg(CsrMaxMessage, 32'hFFFF_FFFF);
      send_span(32'd12, 16'h0F0F, 0, 9);
      go_idle();
      write_reg(CsrHeaderBytes, 32'd6);
      send_span(32'd12, 16'h0F0F, 9, 12);
      go_idle();

      // Random settings, each followed by a few legal messages.
      random_goal = bytes_sent + STREAM_BYTES;
      while (bytes_sent < random_goal) begin
         random_settings();
         // The receiver holds off once, while the first random messages go in.
         hold_off_request = 1'b1;
         gapless = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 4)) send_message(legal_length(), legal_key());
         gapless = 1'b0;
         go_idle();
      end

      // Close the stream with one error; later bytes are dropped.
      reason = close_reason_type'($urandom_range(0, 2));
      h = header_len_in_use();
      key = legal_key();
      case (reason)
         CLOSE_SHORT: len = 32'($urandom_range(0, h));
         CLOSE_LONG: begin
            write_reg(CsrMaxMessage, 32'(h + 1 + $urandom_range(0, 100)));
            len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                               : max_reg + 32'($urandom_range(1, 1000));
         end
         default: begin
            write_reg(CsrMagic, 32'($urandom_range(1, 65535)));
            key = magic_reg ^ 16'h0100;
            len = legal_length();
         end
      endcase
      send_span(len, key, 0, h + 1);
      repeat (6) send_byte(8'($urandom_range(0, 255)));
      go_idle();

      $display("Run covered %0d stream bytes and %0d register writes; %0d result items checked,",
               bytes_sent, reg_writes, results_checked);
      $display("%0d messages delivered, stream closed by %s.", messages_delivered, reason.name());
      if (failures == 0 && pending == 0) begin
         $display("length_prefixed_deframer_unit: match");
      end else begin
         $display("length_prefixed_deframer_unit: mismatch");
      end
      $finish;
   end

endmodule
